>>> design/srtt_pkg.sv
// srtt_pkg: shared types, widths and codes for the send/ack round trip matcher
// no dependencies; used by every module of the block

package srtt_pkg;

	localparam int ID_W     = 32;
	localparam int STAMP_W  = 24;
	localparam int PERIOD_W = 25;

	// default table size and queue depth between the parts
	localparam int TABLE_DEPTH = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd1000000;

	// item kinds
	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// result status codes
	localparam logic STATUS_MATCH = 1'b0;
	localparam logic STATUS_DROP  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [ID_W-1:0]    packet_id;
		logic [STAMP_W-1:0] stamp;
	} item_t;

	typedef struct packed {
		logic               status;
		logic [ID_W-1:0]    matched_id;
		logic [STAMP_W-1:0] round_trip;
	} result_t;

	// raw outcome from the table engine, round trip still to be formed
	typedef struct packed {
		logic               status;
		logic [ID_W-1:0]    packet_id;
		logic [STAMP_W-1:0] ack_stamp;
		logic [STAMP_W-1:0] sent_stamp;
	} back_res_t;

endpackage

>>> design/srtt_front.sv
// srtt_front: input queue that takes send and ack transactions
// depends on srtt_pkg for item_t and the queue depth

module srtt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  srtt_pkg::item_t item,
	output logic            head_valid,
	output srtt_pkg::item_t head,
	input  logic            take
);

	localparam int DEPTH = srtt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	srtt_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr;
	logic             rd;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign wr         = push && !full;
	assign rd         = take && head_valid;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> design/srtt_back.sv
// srtt_back: row of table cells with a two-step sequencer (compare, then shift)
// depends on srtt_pkg for item_t, back_res_t, widths and codes

module srtt_back #(
	parameter int TABLE_DEPTH = srtt_pkg::TABLE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  srtt_pkg::item_t     head,
	output logic                take,
	output logic                res_valid,
	output srtt_pkg::back_res_t res,
	input  logic                res_ready
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic ST_IDLE    = 1'b0;
	localparam logic ST_RESOLVE = 1'b1;

	logic [srtt_pkg::ID_W-1:0]    id_q    [TABLE_DEPTH];
	logic [srtt_pkg::STAMP_W-1:0] stamp_q [TABLE_DEPTH];
	logic [CNT_W-1:0]             count_q;
	logic                         state_q;
	logic [TABLE_DEPTH-1:0]       match;
	logic [TABLE_DEPTH-1:0]       match_q;
	logic [srtt_pkg::ID_W-1:0]    key_q;
	logic [srtt_pkg::STAMP_W-1:0] ack_stamp_q;
	logic                         res_valid_q;
	srtt_pkg::back_res_t          res_q;

	logic                         res_free;
	logic                         tbl_full;
	logic                         do_send;
	logic                         do_append;
	logic                         do_drop;
	logic                         do_ack;
	logic [TABLE_DEPTH-1:0]       below;
	logic [TABLE_DEPTH-1:0]       first;
	logic [TABLE_DEPTH-1:0]       shift;
	logic                         hit;
	logic                         do_remove;
	logic [srtt_pkg::STAMP_W-1:0] sent_stamp;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// the result slot must be free by the end of this cycle to start an item
	assign res_free  = !res_valid_q || res_ready;
	assign take      = (state_q == ST_IDLE) && head_valid && res_free;
	assign tbl_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign do_send   = take && (head.kind == srtt_pkg::KIND_SEND);
	assign do_append = do_send && !tbl_full;
	assign do_drop   = do_send && tbl_full;
	assign do_ack    = take && (head.kind == srtt_pkg::KIND_ACK);

	// every live cell compares its packet number with the head item
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (id_q[i] == head.packet_id);
		end
	end

	// oldest match: ones from bit 0 up to the lowest set bit
	assign below     = match_q ^ (match_q - TABLE_DEPTH'(1));
	assign first     = below & match_q;
	assign shift     = ~below | first;
	assign hit       = |match_q;
	assign do_remove = (state_q == ST_RESOLVE) && hit;

	// stamp of the oldest matching cell
	always_comb begin
		sent_stamp = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sent_stamp = sent_stamp | (first[i] ? stamp_q[i] : '0);
		end
	end

	// cells: append at the young end, or take the younger neighbor to close the gap
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i < TABLE_DEPTH - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (do_append && (CNT_W'(i) == count_q)) begin
					id_q[i]    <= head.packet_id;
					stamp_q[i] <= head.stamp;
				end else if (do_remove && shift[i]) begin
					id_q[i]    <= id_q[i + 1];
					stamp_q[i] <= stamp_q[i + 1];
				end
			end
		end else begin : g_top
			always_ff @(posedge clk) begin
				if (do_append && (CNT_W'(i) == count_q)) begin
					id_q[i]    <= head.packet_id;
					stamp_q[i] <= head.stamp;
				end
			end
		end
	end

	// sequencer, fill count and result slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			match_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_ack) begin
						match_q <= match;
						state_q <= ST_RESOLVE;
					end
					if (do_append) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_RESOLVE: begin
					if (hit) begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_drop || do_remove) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ack key and result payload
	always_ff @(posedge clk) begin
		if (do_ack) begin
			key_q       <= head.packet_id;
			ack_stamp_q <= head.stamp;
		end
		if (do_drop) begin
			res_q.status     <= srtt_pkg::STATUS_DROP;
			res_q.packet_id  <= head.packet_id;
			res_q.ack_stamp  <= '0;
			res_q.sent_stamp <= '0;
		end else if (do_remove) begin
			res_q.status     <= srtt_pkg::STATUS_MATCH;
			res_q.packet_id  <= key_q;
			res_q.ack_stamp  <= ack_stamp_q;
			res_q.sent_stamp <= sent_stamp;
		end
	end

	// fill count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("table fill count above depth");

	// the result slot is always free when a lookup resolves
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESOLVE) |-> !res_valid_q)
		else $error("result slot busy during resolve");

	// a hit removes exactly one entry
	a_hit_removes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESOLVE && hit) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("hit did not remove one entry");

	// only live cells can match
	a_match_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESOLVE && count_q == '0) |-> !hit)
		else $error("match reported in empty table");

endmodule

>>> design/srtt_out.sv
// srtt_out: period register, round trip formation and result queue
// depends on srtt_pkg for back_res_t, result_t, widths and reset period

module srtt_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srtt_pkg::PERIOD_W-1:0] cfg_data,
	input  logic                          res_valid,
	input  srtt_pkg::back_res_t           res,
	output logic                          res_ready,
	output logic                          empty,
	input  logic                          pop,
	output srtt_pkg::result_t             result
);

	localparam int DEPTH = srtt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [srtt_pkg::PERIOD_W-1:0] period_q;
	srtt_pkg::result_t             slot_q [DEPTH];
	logic [PTR_W-1:0]              wr_ptr_q;
	logic [PTR_W-1:0]              rd_ptr_q;
	logic [CNT_W-1:0]              count_q;
	logic                          wr;
	logic                          rd;
	logic [srtt_pkg::STAMP_W-1:0]  diff;
	logic [srtt_pkg::STAMP_W-1:0]  wrap_add;
	srtt_pkg::result_t             entry;

	assign cfg_ready = 1'b1;
	assign res_ready = (count_q != CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign result    = slot_q[rd_ptr_q];
	assign wr        = res_valid && res_ready;
	assign rd        = pop && !empty;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= srtt_pkg::PERIOD_RESET;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	// round trip modulo 2^24, period added when the ack stamp is older
	assign diff     = res.ack_stamp - res.sent_stamp;
	assign wrap_add = (res.ack_stamp < res.sent_stamp) ?
		period_q[srtt_pkg::STAMP_W-1:0] : '0;

	always_comb begin
		entry.status     = res.status;
		entry.matched_id = res.packet_id;
		entry.round_trip = diff + wrap_add;
	end

	// result storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> design/send_ack_rtt_matcher_unit.sv
// An ack that hits passes the input queue, compare step, result register
// and result queue; a dropped send skips the compare step; other items give
// no result. One send per cycle while the result slot is free; an ack holds
// the compare-then-shift sequencer, which takes no item until it resolves.
// Reset: queues and table empty, period back to 1000000; table contents are
// not cleared, so no clearing pass is needed and items are taken at once.

module send_ack_rtt_matcher_unit #(
	parameter int TABLE_DEPTH = srtt_pkg::TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  srtt_pkg::item_t               item,
	output logic                          empty,
	input  logic                          pop,
	output srtt_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srtt_pkg::PERIOD_W-1:0] cfg_data
);

	logic                head_valid;
	srtt_pkg::item_t     head;
	logic                take;
	logic                res_valid;
	srtt_pkg::back_res_t res;
	logic                res_ready;

	// input queue
	srtt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.take       (take)
	);

	// table engine
	srtt_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.take       (take),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	// round trip and result queue
	srtt_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

>>> test/tb.sv
// tb: self-checking testbench for send_ack_rtt_matcher_unit
// depends on srtt_pkg and the block; predicts round trips and drops from its own table copy

module tb;

	localparam int DEPTH         = srtt_pkg::TABLE_DEPTH;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_QUARTER, RX_TRICKLE} rx_mode_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          push      = 1'b0;
	logic                          full;
	srtt_pkg::item_t               item      = '0;
	logic                          empty;
	logic                          pop       = 1'b0;
	srtt_pkg::result_t             result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [srtt_pkg::PERIOD_W-1:0] cfg_data  = '0;

	// predicted table of outstanding packets, oldest at index 0
	logic [srtt_pkg::ID_W-1:0]     tbl_id    [DEPTH];
	logic [srtt_pkg::STAMP_W-1:0]  tbl_stamp [DEPTH];
	int                            tbl_fill   = 0;
	logic [srtt_pkg::PERIOD_W-1:0] cur_period = srtt_pkg::PERIOD_RESET;

	// round trip and drop reports still to come out of the block
	srtt_pkg::result_t outstanding_reports[$];
	int                fail_count = 0;

	// sender burst state
	int burst_left = 0;
	bit no_gaps    = 1'b0;

	// receiver state
	logic     hold_go    = 1'b0;
	logic     hold_seen  = 1'b0;
	int       hold_left  = 0;
	rx_mode_t rx_mode    = RX_STEADY;
	int       mode_left  = 0;
	logic [1:0] rx_phase = '0;

	send_ack_rtt_matcher_unit #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// update the table copy for one accepted transaction, queue any report it causes
	function automatic void track_item(input srtt_pkg::item_t it);
		srtt_pkg::result_t rep;
		logic [31:0]       diff;
		int                hit;
		hit = -1;
		if (it.kind == srtt_pkg::KIND_SEND) begin
			if (tbl_fill >= DEPTH) begin
				rep.status     = srtt_pkg::STATUS_DROP;
				rep.matched_id = it.packet_id;
				rep.round_trip = '0;
				outstanding_reports.push_back(rep);
			end else begin
				tbl_id[tbl_fill]    = it.packet_id;
				tbl_stamp[tbl_fill] = it.stamp;
				tbl_fill++;
			end
		end else begin
			for (int i = 0; i < tbl_fill && hit < 0; i++)
				if (tbl_id[i] == it.packet_id)
					hit = i;
			if (hit >= 0) begin
				// 32-bit wrapping difference, period added when the ack stamp is older
				diff = {8'b0, it.stamp} - {8'b0, tbl_stamp[hit]};
				if (it.stamp < tbl_stamp[hit])
					diff = diff + {7'b0, cur_period};
				rep.status     = srtt_pkg::STATUS_MATCH;
				rep.matched_id = it.packet_id;
				rep.round_trip = diff[srtt_pkg::STAMP_W-1:0];
				outstanding_reports.push_back(rep);
				for (int j = hit; j + 1 < tbl_fill; j++) begin
					tbl_id[j]    = tbl_id[j+1];
					tbl_stamp[j] = tbl_stamp[j+1];
				end
				tbl_fill--;
			end
		end
	endfunction

	function automatic srtt_pkg::item_t make_item(input logic k,
			input logic [srtt_pkg::ID_W-1:0] id, input logic [srtt_pkg::STAMP_W-1:0] st);
		srtt_pkg::item_t it;
		it.kind      = k;
		it.packet_id = id;
		it.stamp     = st;
		return it;
	endfunction

	// mostly below the period, sometimes extremes and out-of-range values
	function automatic logic [srtt_pkg::STAMP_W-1:0] pick_stamp();
		logic [srtt_pkg::PERIOD_W-1:0] lim;
		logic [31:0]                   raw;
		int                            r;
		r   = $urandom_range(0, 19);
		lim = (cur_period == '0 || cur_period > 25'd16777216) ? 25'd16777216 : cur_period;
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		if (r == 2) begin
			raw = $urandom;
			return raw[srtt_pkg::STAMP_W-1:0];
		end
		raw = $urandom_range(0, lim - 1);
		return raw[srtt_pkg::STAMP_W-1:0];
	endfunction

	// small pool gives duplicates, the rest spans all 32 bits
	function automatic logic [srtt_pkg::ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return '0;
		if (r < 4)
			return '1;
		if (r < 30)
			return $urandom_range(0, 15);
		return $urandom;
	endfunction

	// offer one transaction, with random gaps between bursts; push stays high afterwards
	task automatic send_item(input srtt_pkg::item_t it);
		int gap;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		track_item(it);
	endtask

	// wait for the block to go quiet, then write the period register
	task automatic set_period(input logic [srtt_pkg::PERIOD_W-1:0] val);
		push <= 1'b0;
		while (outstanding_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cur_period = val;
		cfg_valid <= 1'b0;
	endtask

	// extremes, duplicates, misses and the wrapped difference
	task automatic test_directed_cases();
		send_item(make_item(srtt_pkg::KIND_SEND, 32'h0, 24'h0));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'hFFFF_FFFF, 24'hFF_FFFF));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'd5, 24'd100));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'd5, 24'd200));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'hFFFF_FFFF, 24'hFF_FFFF));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'h0, 24'hFF_FFFF));
		// older duplicate first, with a negative difference
		send_item(make_item(srtt_pkg::KIND_ACK, 32'd5, 24'd50));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'd5, 24'd300));
		// both duplicates gone, then an id never sent
		send_item(make_item(srtt_pkg::KIND_ACK, 32'd5, 24'd0));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'd12345, 24'd1));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'd7, 24'd999999));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'd7, 24'd0));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'd8, 24'd10));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'd8, 24'd10));
		// ack from the middle of the table closes the gap
		send_item(make_item(srtt_pkg::KIND_SEND, 32'hA5A5_A5A5, 24'h5A_5A5A));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'h5A5A_5A5A, 24'hA5_A5A5));
		send_item(make_item(srtt_pkg::KIND_SEND, 32'h0000_0001, 24'h00_0001));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'h5A5A_5A5A, 24'h00_0000));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'h0000_0001, 24'h00_0002));
		send_item(make_item(srtt_pkg::KIND_ACK, 32'hA5A5_A5A5, 24'hFF_FFFF));
	endtask

	// send/ack sequences on live ids, with misses as noise
	task automatic test_random_traffic(input int n, input int send_pct);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < send_pct || (tbl_fill == 0 && r < 93))
				send_item(make_item(srtt_pkg::KIND_SEND, pick_id(), pick_stamp()));
			else if (r < 93)
				send_item(make_item(srtt_pkg::KIND_ACK,
					tbl_id[$urandom_range(0, tbl_fill - 1)], pick_stamp()));
			else
				send_item(make_item(srtt_pkg::KIND_ACK, pick_id(), pick_stamp()));
		end
	endtask

	// receiver holds off while the table fills and drops back up the block
	task automatic test_full_table_backpressure();
		no_gaps = 1'b1;
		hold_go <= ~hold_go;
		while (tbl_fill < DEPTH)
			send_item(make_item(srtt_pkg::KIND_SEND, $urandom, pick_stamp()));
		repeat (24)
			send_item(make_item(srtt_pkg::KIND_SEND, pick_id(), pick_stamp()));
		no_gaps = 1'b0;
		// drain in random order
		while (tbl_fill > 0)
			send_item(make_item(srtt_pkg::KIND_ACK,
				tbl_id[$urandom_range(0, tbl_fill - 1)], pick_stamp()));
	endtask

	// several periods, extremes among them, ending on the reset value
	task automatic test_period_settings();
		logic [srtt_pkg::PERIOD_W-1:0] periods[7];
		logic [31:0]                   raw;
		raw        = $urandom_range(2, 16777215);
		periods[0] = 25'd1;
		periods[1] = 25'd16777216;
		periods[2] = 25'd0;
		periods[3] = 25'h1FF_FFFF;
		periods[4] = 25'd100;
		periods[5] = raw[srtt_pkg::PERIOD_W-1:0];
		periods[6] = srtt_pkg::PERIOD_RESET;
		for (int p = 0; p < 7; p++) begin
			set_period(periods[p]);
			test_random_traffic(140, (p % 3 == 1) ? 70 : 45);
		end
	endtask

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			pop       <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(30, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			rx_phase <= rx_phase + 2'd1;
			unique case (rx_mode)
				RX_STEADY:  pop <= 1'b1;
				RX_COIN:    pop <= ($urandom_range(0, 1) == 1);
				RX_QUARTER: pop <= (rx_phase == 2'd0);
				default:    pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// compare each popped transaction with the oldest prediction
	always @(posedge clk) begin
		srtt_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (outstanding_reports.size() == 0) begin
				$display("%0t: unexpected result status %0b id %h round_trip %h", $time,
					result.status, result.matched_id, result.round_trip);
				fail_count++;
			end else begin
				want = outstanding_reports.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0b actual %0b", $time,
						want.status, result.status);
					fail_count++;
				end
				if (result.matched_id !== want.matched_id) begin
					$display("%0t: matched_id expected %h actual %h", $time,
						want.matched_id, result.matched_id);
					fail_count++;
				end
				if (result.round_trip !== want.round_trip) begin
					$display("%0t: round_trip expected %h actual %h", $time,
						want.round_trip, result.round_trip);
					fail_count++;
				end
			end
		end
	end

	// test sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(150, 45);
		test_full_table_backpressure();
		test_period_settings();
		push <= 1'b0;
		while (outstanding_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> send_ack_rtt_matcher_unit.f
design/srtt_pkg.sv
design/srtt_front.sv
design/srtt_back.sv
design/srtt_out.sv
design/send_ack_rtt_matcher_unit.sv
test/tb.sv
